// ===== src/aesd_pkg.sv =====
// Shared types, tables and round functions for the AES-128 decryptor.
`default_nettype none
package aesd_pkg;

  localparam int NumRounds = 10;
  localparam int KeyW = 64;
  localparam int BlockW = 128;
  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  typedef logic [BlockW-1:0] block_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  // Byte i sits at bits [127-8i -: 8].
  function automatic block_t inv_shift_sub(input block_t s);
    block_t o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = inv_sbox(s[127-8*(4*((c-r+4)%4)+r) -: 8]);
      end
    end
    inv_shift_sub = o;
  endfunction

  function automatic logic [7:0] mul_e(input logic [7:0] a, input logic [3:0] k);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    mul_e = (k[0] ? a : 8'h00) ^ (k[1] ? a2 : 8'h00) ^ (k[2] ? a4 : 8'h00) ^ (k[3] ? a8 : 8'h00);
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      o[127-32*c -: 8] = mul_e(a0,4'd14)^mul_e(a1,4'd11)^mul_e(a2,4'd13)^mul_e(a3,4'd9);
      o[119-32*c -: 8] = mul_e(a0,4'd9)^mul_e(a1,4'd14)^mul_e(a2,4'd11)^mul_e(a3,4'd13);
      o[111-32*c -: 8] = mul_e(a0,4'd13)^mul_e(a1,4'd9)^mul_e(a2,4'd14)^mul_e(a3,4'd11);
      o[103-32*c -: 8] = mul_e(a0,4'd11)^mul_e(a1,4'd13)^mul_e(a2,4'd9)^mul_e(a3,4'd14);
    end
    inv_mix = o;
  endfunction

  // One step of the key schedule.
  function automatic block_t next_key(input block_t k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// ===== src/aes128_block_decrypt.sv =====
// AES-128 inverse cipher, one round per pipeline stage, with key schedule.
//
// Decrypts one 128-bit block per clock cycle while not stalled. The datapath is
// eleven register stages: stage 0 adds round key 10, stages 1 to 9 each run one
// inverse round, and stage 10 runs the last round and drives the outputs
// directly. A stall freezes the whole pipe. Writing either key register starts
// an expansion that derives one round key per cycle through the schedule unit;
// in_stall_o stays high while it runs, so later blocks always see the new round
// keys. Write keys only while the pipe is empty. After reset the expansion of
// the all-zero key runs the same way and holds off input until it is done.
`default_nettype none
module aes128_block_decrypt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] cipher_high_i,
  input  wire logic [63:0] cipher_low_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      plain_high_o,
  output logic [63:0]      plain_low_o
);

  localparam int NR = aesd_pkg::NumRounds;

  logic [63:0] key_hi_q, key_lo_q;
  aesd_pkg::block_t rk_q [NR+1];
  logic [3:0]  kx_cnt_q;
  logic        kx_busy_q;
  logic [7:0]  rcon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q  <= '0;
      key_lo_q  <= '0;
      kx_busy_q <= 1'b1;
      kx_cnt_q  <= '0;
      rcon_q    <= 8'h01;
    end else if (cfg_we_i) begin
      case (aesd_pkg::cfg_reg_e'(cfg_idx_i))
        aesd_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data_i;
        aesd_pkg::REG_KEY_LOW:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
      kx_busy_q <= 1'b1;
      kx_cnt_q  <= '0;
      rcon_q    <= 8'h01;
    end else if (kx_busy_q) begin
      kx_cnt_q <= kx_cnt_q + 4'd1;
      // round key 1 uses the first round constant
      if (kx_cnt_q != '0) rcon_q <= aesd_pkg::xtime(rcon_q);
      if (kx_cnt_q == 4'(NR)) kx_busy_q <= 1'b0;
    end
  end

  // Round key 0 is the key itself; derive one more per cycle.
  always_ff @(posedge clk_i) begin
    if (kx_busy_q) begin
      if (kx_cnt_q == '0) rk_q[0] <= {key_hi_q, key_lo_q};
      else rk_q[kx_cnt_q] <= aesd_pkg::next_key(rk_q[kx_cnt_q - 4'd1], rcon_q);
    end
  end

  logic             vld_q [NR+1];
  aesd_pkg::block_t st_q  [NR+1];
  logic             adv;

  assign adv        = !(out_valid_o && out_stall_i);
  // hold off input while a result waits or the round keys are being built
  assign in_stall_o = !adv || kx_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NR; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i && !in_stall_o;
      for (int i = 1; i <= NR; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= {cipher_high_i, cipher_low_i} ^ rk_q[NR];
      for (int i = 1; i < NR; i++) begin
        st_q[i] <= aesd_pkg::inv_mix(aesd_pkg::inv_shift_sub(st_q[i-1]) ^ rk_q[NR-i]);
      end
      st_q[NR] <= aesd_pkg::inv_shift_sub(st_q[NR-1]) ^ rk_q[0];
    end
  end

  assign out_valid_o  = vld_q[NR];
  assign plain_high_o = st_q[NR][127:64];
  assign plain_low_o  = st_q[NR][63:0];

endmodule
`default_nettype wire

// ===== src/aesd_checker.sv =====
// Port-level checks for the AES-128 decryptor, bound to the top level.
`default_nettype none
module aesd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] plain_high_o,
  input wire logic [63:0] plain_low_o
);

  // A waiting result holds off input.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o) else $error("no stall under backpressure");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(plain_high_o)
      && $stable(plain_low_o))) else $error("stalled result changed");

  // A key write starts the schedule, which blocks input.
  a_key_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o) else $error("input open during key expansion");

  a_known_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({out_valid_o, in_stall_o})) else $error("unknown handshake");

endmodule

bind aes128_block_decrypt aesd_checker u_aesd_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the pipelined AES-128 block decryptor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int ItemsPerPhase = 205;
  localparam int NumPhases = 8;
  localparam int IdleLimit = 2000;
  localparam int ExpandWait = 16;
  localparam int DrainWait = 20;

  typedef struct {
    logic [127:0] key;
    logic [127:0] ct;
    bit           known;
    logic [127:0] pt;
  } vec_row_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  aesd_pkg::cfg_reg_e cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [63:0] cipher_high_i, cipher_low_i;
  logic        out_valid_o, out_stall_i;
  logic [63:0] plain_high_o, plain_low_o;

  aes128_block_decrypt uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cipher_high_i(cipher_high_i), .cipher_low_i(cipher_low_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .plain_high_o(plain_high_o), .plain_low_o(plain_low_o)
  );

  logic [7:0]   fwd_sbox [256];
  logic [7:0]   rev_sbox [256];
  logic [127:0] round_keys [11];
  logic [127:0] cur_key;
  logic [127:0] plain_q [$];
  int           mismatches;
  int           idle_cycles;
  int           out_hold;
  bit           calm;
  vec_row_t     rows [10];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Build both S-box tables from the field inverse and the affine map.
  function automatic void build_sboxes();
    logic [7:0] inv, y;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int c = 1; c < 256; c++) begin
        if (gmul(x[7:0], c[7:0]) == 8'h01) inv = c[7:0];
      end
      y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sbox[x] = y;
      rev_sbox[y] = x[7:0];
    end
  endfunction

  function automatic void expand_round_keys(input logic [127:0] k);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fwd_sbox[t[23:16]] ^ rc, fwd_sbox[t[15:8]], fwd_sbox[t[7:0]], fwd_sbox[t[31:24]]};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = rev_sbox[s[127-8*(4*((c-r+4)%4)+r) -: 8]];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] unmix_columns(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] b0, b1, b2, b3;
    for (int c = 0; c < 4; c++) begin
      b0 = s[127-32*c -: 8];
      b1 = s[119-32*c -: 8];
      b2 = s[111-32*c -: 8];
      b3 = s[103-32*c -: 8];
      o[127-32*c -: 8] = gmul(b0, 8'd14) ^ gmul(b1, 8'd11) ^ gmul(b2, 8'd13) ^ gmul(b3, 8'd9);
      o[119-32*c -: 8] = gmul(b0, 8'd9) ^ gmul(b1, 8'd14) ^ gmul(b2, 8'd11) ^ gmul(b3, 8'd13);
      o[111-32*c -: 8] = gmul(b0, 8'd13) ^ gmul(b1, 8'd9) ^ gmul(b2, 8'd14) ^ gmul(b3, 8'd11);
      o[103-32*c -: 8] = gmul(b0, 8'd11) ^ gmul(b1, 8'd13) ^ gmul(b2, 8'd9) ^ gmul(b3, 8'd14);
    end
    return o;
  endfunction

  function automatic logic [127:0] decrypt_block(input logic [127:0] ct);
    logic [127:0] s;
    s = ct ^ round_keys[10];
    for (int r = 9; r > 0; r--) begin
      s = unshift_unsub(s) ^ round_keys[r];
      s = unmix_columns(s);
    end
    return unshift_unsub(s) ^ round_keys[0];
  endfunction

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 15))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_drained();
    while (plain_q.size() != 0) @(posedge clk_i);
  endtask

  // Drain the pipe, write the selected key halves, then let the schedule finish.
  task automatic load_key(input bit wr_hi, input bit wr_lo, input logic [127:0] k);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (wr_hi) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= aesd_pkg::REG_KEY_HIGH;
      cfg_data_i <= k[127:64];
      cur_key[127:64] = k[127:64];
      @(posedge clk_i);
    end
    if (wr_lo) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= aesd_pkg::REG_KEY_LOW;
      cfg_data_i <= k[63:0];
      cur_key[63:0] = k[63:0];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    expand_round_keys(cur_key);
    repeat (ExpandWait) @(posedge clk_i);
  endtask

  task automatic send_block(input logic [127:0] ct, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cipher_high_i <= ct[127:64];
    cipher_low_i <= ct[63:0];
    plain_q.push_back(decrypt_block(ct));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Receive side: check each beat and draw a new stall length.
  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (plain_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h %h", plain_high_o, plain_low_o);
      end else begin
        want = plain_q.pop_front();
        if (plain_high_o !== want[127:64] || plain_low_o !== want[63:0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("plain mismatch: exp %h %h got %h %h",
                     want[127:64], want[63:0], plain_high_o, plain_low_o);
        end
      end
      out_hold = draw_gap();
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_stall_i <= (out_hold > 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [127:0] k;
    int mode;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = aesd_pkg::REG_KEY_HIGH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cipher_high_i = '0;
    cipher_low_i = '0;
    out_stall_i = 1'b0;
    out_hold = 0;
    mismatches = 0;
    idle_cycles = 0;
    calm = 1'b0;
    cur_key = '0;
    build_sboxes();
    expand_round_keys(cur_key);

    rows[0] = '{128'h0, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1, 128'h0};
    rows[1] = '{128'h0, 128'h0, 1'b0, 128'h0};
    rows[2] = '{128'h0, '1, 1'b0, 128'h0};
    rows[3] = '{128'h0, {16{8'haa}}, 1'b0, 128'h0};
    rows[4] = '{128'h0, {16{8'h55}}, 1'b0, 128'h0};
    rows[5] = '{128'h000102030405060708090a0b0c0d0e0f, 128'h69c4e0d86a7b0430d8cdb78070b4c55a,
                1'b1, 128'h00112233445566778899aabbccddeeff};
    rows[6] = '{128'h000102030405060708090a0b0c0d0e0f, '1, 1'b0, 128'h0};
    rows[7] = '{'1, 128'h0, 1'b0, 128'h0};
    rows[8] = '{'1, '1, 1'b0, 128'h0};
    rows[9] = '{128'h80000000000000000000000000000001, 128'h0123456789abcdeffedcba9876543210,
                1'b0, 128'h0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // zero-key schedule runs after reset
    repeat (ExpandWait) @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].key !== cur_key) load_key(1'b1, 1'b1, rows[i].key);
      if (rows[i].known && decrypt_block(rows[i].ct) !== rows[i].pt) begin
        mismatches++;
        if (mismatches <= 10) $display("known vector %0d disagrees with predictor", i);
      end
      send_block(rows[i].ct, draw_gap());
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      mode = ph % 4;
      calm = (ph == 2);
      k = {$urandom, $urandom, $urandom, $urandom};
      if (ph == 1) k = '1;
      if (ph == 5) k = '0;
      // some phases touch just one half of the key
      load_key(mode != 3, mode != 1, k);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (ph == 4 && n == ItemsPerPhase / 2) begin
          in_valid_i <= 1'b0;
          wait_drained();
          @(posedge clk_i);
        end
        send_block({rand_half(), rand_half()}, draw_gap());
      end
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && plain_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/aesd_pkg.sv
src/aes128_block_decrypt.sv
src/aesd_checker.sv
tb/tb_top.sv
